### design/mqlf_pkg.sv
// ----------------------------------------------------------------------------
// mqlf_pkg
// Shared types and constants of the multi-queue linked-list FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mqlf_pkg;

  localparam int QUEUE_COUNT = 8;
  localparam int POOL_NODES  = 256;
  localparam int VALUE_BITS  = 32;

  localparam int QID_W  = 3;
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = $clog2(POOL_NODES + 1);
  localparam int REQ_W  = 2;
  localparam int STS_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_QUERY = 2'd3
  } req_type_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_INACTIVE  = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_POOL_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_HEAD,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic update;
    logic capture_head;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_head;
  } sts_t;

endpackage

`default_nettype wire

### design/mqlf_ifs.sv
// ----------------------------------------------------------------------------
// mqlf_ifs
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqlf_req_if;
  import mqlf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [QID_W-1:0]      queue_id;
  logic [VALUE_BITS-1:0] value_in;

  modport source (output valid, output req_type, output queue_id, output value_in,
                  input ready);
  modport sink   (input valid, input req_type, input queue_id, input value_in,
                  output ready);
endinterface

interface mqlf_rsp_if;
  import mqlf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STS_W-1:0]      status;
  logic [VALUE_BITS-1:0] value_out;
  logic [CNT_W-1:0]      occupancy;
  logic                  queue_empty;
  logic [VALUE_BITS-1:0] head_value;

  modport source (output valid, output status, output value_out, output occupancy,
                  output queue_empty, output head_value, input ready);
  modport sink   (input valid, input status, input value_out, input occupancy,
                  input queue_empty, input head_value, output ready);
endinterface

`default_nettype wire

### design/mqlf_ram.sv
// ----------------------------------------------------------------------------
// mqlf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mqlf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/mqlf_ctrl.sv
// ----------------------------------------------------------------------------
// mqlf_ctrl
// Request sequencer: read, update, optional head read, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mqlf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire mqlf_pkg::sts_t  sts,
  output mqlf_pkg::cmd_t       cmd
);
  import mqlf_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = sts.need_head ? ST_HEAD : ST_DONE;
      ST_HEAD:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_UPDATE: cmd.update       = 1'b1;
      ST_HEAD:   cmd.capture_head = 1'b1;
      ST_DONE:   cmd.load_out     = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mqlf_dp.sv
// ----------------------------------------------------------------------------
// mqlf_dp
// Queue pointers, free list, node memories and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mqlf_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mqlf_pkg::cmd_t                  cmd,
  output mqlf_pkg::sts_t                       sts,
  input  wire logic                            cfg_we,
  input  wire logic [mqlf_pkg::QUEUE_COUNT-1:0] cfg_wdata,
  input  wire logic [mqlf_pkg::REQ_W-1:0]      req_type,
  input  wire logic [mqlf_pkg::QID_W-1:0]      queue_id,
  input  wire logic [mqlf_pkg::VALUE_BITS-1:0] value_in,
  output logic      [mqlf_pkg::STS_W-1:0]      status,
  output logic      [mqlf_pkg::VALUE_BITS-1:0] value_out,
  output logic      [mqlf_pkg::CNT_W-1:0]      occupancy,
  output logic                                 queue_empty,
  output logic      [mqlf_pkg::VALUE_BITS-1:0] head_value
);
  import mqlf_pkg::*;

  logic [QUEUE_COUNT-1:0] qenable_r;
  req_type_t              req_r;
  logic [QID_W-1:0]       qid_r;
  logic [VALUE_BITS-1:0]  val_r;

  logic [NODE_W-1:0] head_idx_r [QUEUE_COUNT];
  logic [NODE_W-1:0] tail_idx_r [QUEUE_COUNT];
  logic [CNT_W-1:0]  qcnt_r     [QUEUE_COUNT];
  logic [NODE_W-1:0] head_idx_nxt, tail_idx_nxt;
  logic [CNT_W-1:0]  qcnt_nxt;

  logic [NODE_W-1:0] free_head_r, free_head_nxt;
  logic [NODE_W-1:0] free_tail_r, free_tail_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;

  status_t               res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0] res_pop_r, res_pop_nxt;
  logic [VALUE_BITS-1:0] res_head_r, res_head_nxt;
  logic [CNT_W-1:0]      res_occ_r, res_occ_nxt;
  logic                  res_empty_r, res_empty_nxt;

  logic [STS_W-1:0]      out_status_r;
  logic [VALUE_BITS-1:0] out_pop_r;
  logic [CNT_W-1:0]      out_occ_r;
  logic                  out_empty_r;
  logic [VALUE_BITS-1:0] out_head_r;

  logic [NODE_W-1:0]     hd, tl;
  logic [CNT_W-1:0]      cnt;
  logic                  en;
  logic                  need_head;

  logic                  v_we, l_we;
  logic [NODE_W-1:0]     v_waddr, v_raddr, l_waddr, l_raddr;
  logic [VALUE_BITS-1:0] v_wdata, v_rdata;
  logic [NODE_W-1:0]     l_wdata, l_rdata;

  mqlf_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_value_ram (
    .clk   (clk),
    .we    (v_we && cmd.update),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  mqlf_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (l_we && cmd.update),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign hd  = head_idx_r[qid_r];
  assign tl  = tail_idx_r[qid_r];
  assign cnt = qcnt_r[qid_r];
  assign en  = qenable_r[qid_r];

  assign v_raddr = cmd.update ? l_rdata : hd;
  assign l_raddr = (req_r == REQ_POP) ? hd : free_head_r;

  assign sts.need_head = need_head;

  always_comb begin
    head_idx_nxt   = hd;
    tail_idx_nxt   = tl;
    qcnt_nxt       = cnt;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    free_cnt_nxt   = free_cnt_r;
    fresh_nxt      = fresh_r;
    v_we           = 1'b0;
    v_waddr        = free_head_r;
    v_wdata        = val_r;
    l_we           = 1'b0;
    l_waddr        = tl;
    l_wdata        = free_head_r;
    res_status_nxt = STS_OK;
    res_pop_nxt    = '0;
    res_head_nxt   = '0;
    need_head      = 1'b0;
    if (!en) begin
      res_status_nxt = STS_INACTIVE;
    end else begin
      case (req_r)
        REQ_PUSH: begin
          if (free_cnt_r != '0) begin
            v_we          = 1'b1;
            v_waddr       = free_head_r;
            free_head_nxt = l_rdata;
            free_cnt_nxt  = free_cnt_r - 1'b1;
          end else if (fresh_r < CNT_W'(POOL_NODES)) begin
            v_we      = 1'b1;
            v_waddr   = fresh_r[NODE_W-1:0];
            fresh_nxt = fresh_r + 1'b1;
          end else begin
            res_status_nxt = STS_POOL_FULL;
          end
          if (v_we) begin
            if (cnt == '0) begin
              head_idx_nxt = v_waddr;
              res_head_nxt = val_r;
            end else begin
              l_we         = 1'b1;
              l_waddr      = tl;
              l_wdata      = v_waddr;
              res_head_nxt = v_rdata;
            end
            tail_idx_nxt = v_waddr;
            qcnt_nxt     = cnt + 1'b1;
          end else if (cnt != '0) begin
            res_head_nxt = v_rdata;
          end
        end
        REQ_POP: begin
          if (cnt == '0) begin
            res_status_nxt = STS_EMPTY;
          end else begin
            res_pop_nxt   = v_rdata;
            head_idx_nxt  = l_rdata;
            qcnt_nxt      = cnt - 1'b1;
            l_we          = 1'b1;
            l_waddr       = hd;
            l_wdata       = free_head_r;
            if (free_cnt_r == '0) begin
              free_tail_nxt = hd;
            end
            free_head_nxt = hd;
            free_cnt_nxt  = free_cnt_r + 1'b1;
            need_head     = (cnt != CNT_W'(1));
          end
        end
        REQ_CLEAR: begin
          if (cnt != '0) begin
            if (free_cnt_r == '0) begin
              free_head_nxt = hd;
            end else begin
              l_we    = 1'b1;
              l_waddr = free_tail_r;
              l_wdata = hd;
            end
            free_tail_nxt = tl;
            free_cnt_nxt  = free_cnt_r + cnt;
            qcnt_nxt      = '0;
          end
        end
        default: begin
          if (cnt != '0) begin
            res_head_nxt = v_rdata;
          end
        end
      endcase
    end
    res_occ_nxt   = en ? qcnt_nxt : '0;
    res_empty_nxt = !en || (qcnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qenable_r   <= '0;
      free_head_r <= '0;
      free_tail_r <= '0;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        qcnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        qenable_r <= cfg_wdata;
      end
      if (cmd.update) begin
        free_head_r   <= free_head_nxt;
        free_tail_r   <= free_tail_nxt;
        free_cnt_r    <= free_cnt_nxt;
        fresh_r       <= fresh_nxt;
        qcnt_r[qid_r] <= qcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= req_type_t'(req_type);
      qid_r <= queue_id;
      val_r <= value_in;
    end
    if (cmd.update) begin
      head_idx_r[qid_r] <= head_idx_nxt;
      tail_idx_r[qid_r] <= tail_idx_nxt;
      res_status_r      <= res_status_nxt;
      res_pop_r         <= res_pop_nxt;
      res_head_r        <= res_head_nxt;
      res_occ_r         <= res_occ_nxt;
      res_empty_r       <= res_empty_nxt;
    end
    if (cmd.capture_head) begin
      res_head_r <= v_rdata;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_pop_r    <= res_pop_r;
      out_occ_r    <= res_occ_r;
      out_empty_r  <= res_empty_r;
      out_head_r   <= res_head_r;
    end
  end

  assign status      = out_status_r;
  assign value_out   = out_pop_r;
  assign occupancy   = out_occ_r;
  assign queue_empty = out_empty_r;
  assign head_value  = out_head_r;

endmodule

`default_nettype wire

### design/multi_queue_linked_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_linked_fifo
// Eight FIFO queues sharing one pool of linked nodes with a free list.
// ----------------------------------------------------------------------------
// Sequence: a request is latched, the node value and link memories are read,
// then updated; a pop that leaves the queue non-empty adds a read of the new
// head. The result then moves to the output register once that is free, and
// only then is the next request accepted (read-then-write memory sequence).
// A finished result waits in the output register while the next request is
// taken. Reset clears counters, free list and enables; no memory clearing.
`default_nettype none

module multi_queue_linked_fifo (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  mqlf_req_if.sink                               in_req,
  mqlf_rsp_if.source                             out_rsp,
  input  wire logic                              cfg_we,
  input  wire logic [mqlf_pkg::QUEUE_COUNT-1:0]  cfg_wdata
);
  import mqlf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mqlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mqlf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_type    (in_req.req_type),
    .queue_id    (in_req.queue_id),
    .value_in    (in_req.value_in),
    .status      (out_rsp.status),
    .value_out   (out_rsp.value_out),
    .occupancy   (out_rsp.occupancy),
    .queue_empty (out_rsp.queue_empty),
    .head_value  (out_rsp.head_value)
  );

endmodule

`default_nettype wire

### bench/tb_multi_queue_linked_fifo.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_linked_fifo
// Self-checking bench for the shared-pool linked-list FIFO. Directed requests
// cover the queue-enable, empty, clear, query and disable cases. Random
// traffic then runs under several enable masks, with a phase that fills the
// node pool until pushes are refused. A tracker mirrors the queues, the free
// list and the pool, and each result is checked against it in order.
// ----------------------------------------------------------------------------
module tb_multi_queue_linked_fifo;
  timeunit 1ns;
  timeprecision 1ps;
  import mqlf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      occupancy;
    logic                  queue_empty;
    logic [VALUE_BITS-1:0] head_value;
  } queue_result_t;

  class linked_queue_tracker;
    logic [QUEUE_COUNT-1:0] enable_bits;
    logic [NODE_W-1:0]      head_ix [QUEUE_COUNT];
    logic [NODE_W-1:0]      tail_ix [QUEUE_COUNT];
    int                     qcount  [QUEUE_COUNT];
    logic [VALUE_BITS-1:0]  node_val [POOL_NODES];
    logic [NODE_W-1:0]      node_nxt [POOL_NODES];
    logic [NODE_W-1:0]      free_hd;
    logic [NODE_W-1:0]      free_tl;
    int                     free_cnt;
    int                     fresh_cnt;
    queue_result_t          awaited_results [$];
    int                     errors;

    function new();
      enable_bits = '0;
      free_hd     = '0;
      free_tl     = '0;
      free_cnt    = 0;
      fresh_cnt   = 0;
      errors      = 0;
      foreach (qcount[i]) qcount[i] = 0;
    endfunction

    function void set_enable(logic [QUEUE_COUNT-1:0] bits);
      enable_bits = bits;
    endfunction

    function int nodes_left();
      return free_cnt + (POOL_NODES - fresh_cnt);
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    function void note_request(req_type_t r, logic [QID_W-1:0] q,
                               logic [VALUE_BITS-1:0] v);
      queue_result_t     e;
      logic [NODE_W-1:0] n;
      logic              got;
      e.status      = STS_OK;
      e.value_out   = '0;
      e.occupancy   = '0;
      e.queue_empty = 1'b1;
      e.head_value  = '0;
      if (!enable_bits[q]) begin
        e.status = STS_INACTIVE;
        awaited_results.push_back(e);
        return;
      end
      case (r)
        REQ_PUSH: begin
          got = 1'b1;
          n   = '0;
          if (free_cnt != 0) begin
            n        = free_hd;
            free_hd  = node_nxt[n];
            free_cnt = free_cnt - 1;
          end else if (fresh_cnt < POOL_NODES) begin
            n         = fresh_cnt[NODE_W-1:0];
            fresh_cnt = fresh_cnt + 1;
          end else begin
            got = 1'b0;
          end
          if (got) begin
            node_val[n] = v;
            node_nxt[n] = '0;
            if (qcount[q] == 0) head_ix[q] = n;
            else node_nxt[tail_ix[q]] = n;
            tail_ix[q] = n;
            qcount[q]  = qcount[q] + 1;
          end else begin
            e.status = STS_POOL_FULL;
          end
        end
        REQ_POP: begin
          if (qcount[q] == 0) begin
            e.status = STS_EMPTY;
          end else begin
            n           = head_ix[q];
            e.value_out = node_val[n];
            head_ix[q]  = node_nxt[n];
            qcount[q]   = qcount[q] - 1;
            node_nxt[n] = free_hd;
            if (free_cnt == 0) free_tl = n;
            free_hd  = n;
            free_cnt = free_cnt + 1;
          end
        end
        REQ_CLEAR: begin
          if (qcount[q] > 0) begin
            if (free_cnt == 0) free_hd = head_ix[q];
            else node_nxt[free_tl] = head_ix[q];
            free_tl   = tail_ix[q];
            free_cnt  = free_cnt + qcount[q];
            qcount[q] = 0;
          end
        end
        default: begin
        end
      endcase
      e.occupancy = qcount[q][CNT_W-1:0];
      if (qcount[q] != 0) begin
        e.queue_empty = 1'b0;
        e.head_value  = node_val[head_ix[q]];
      end
      awaited_results.push_back(e);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h occ=%0d empty=%b head=%h",
                 $time, got.status, got.value_out, got.occupancy, got.queue_empty,
                 got.head_value);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch", $time);
        $display("  expected status=%0d value=%h occ=%0d empty=%b head=%h",
                 want.status, want.value_out, want.occupancy, want.queue_empty,
                 want.head_value);
        $display("  actual   status=%0d value=%h occ=%0d empty=%b head=%h",
                 got.status, got.value_out, got.occupancy, got.queue_empty,
                 got.head_value);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_we;
  logic [QUEUE_COUNT-1:0] cfg_wdata;
  logic                   idle_on;
  int                     ready_hold;
  int unsigned            cycle_count = 0;
  linked_queue_tracker    sb;

  mqlf_req_if req_if ();
  mqlf_rsp_if rsp_if ();

  multi_queue_linked_fifo u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_rsp   (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_multi_queue_linked_fifo NOT OK");
      $finish;
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    ready_hold   = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
        rsp_if.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        ready_hold   = $urandom_range(0, 9);
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status      = status_t'(rsp_if.status);
      got.value_out   = rsp_if.value_out;
      got.occupancy   = rsp_if.occupancy;
      got.queue_empty = rsp_if.queue_empty;
      got.head_value  = rsp_if.head_value;
      sb.check_result(got);
    end
  end

  task automatic send_req(input req_type_t r, input logic [QID_W-1:0] q,
                          input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
    @(negedge clk);
    req_if.valid    = 1'b1;
    req_if.req_type = r;
    req_if.queue_id = q;
    req_if.value_in = v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r, q, v);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input logic [QUEUE_COUNT-1:0] bits);
    drain_results();
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = bits;
    @(posedge clk);
    sb.set_enable(bits);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random(input logic [QUEUE_COUNT-1:0] en);
    int                    pick;
    req_type_t             r;
    logic [QID_W-1:0]      q;
    logic [VALUE_BITS-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 50) r = REQ_PUSH;
    else if (pick < 80) r = REQ_POP;
    else if (pick < 90) r = REQ_CLEAR;
    else r = REQ_QUERY;
    q = QID_W'($urandom_range(0, QUEUE_COUNT - 1));
    if (en != '0 && $urandom_range(0, 3) != 0) begin
      while (!en[q]) q = QID_W'($urandom_range(0, QUEUE_COUNT - 1));
    end
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    send_req(r, q, v);
  endtask

  task automatic run_random(input logic [QUEUE_COUNT-1:0] en, input int count);
    write_enable(en);
    repeat (count) send_random(en);
  endtask

  initial begin
    int fill;
    sb = new();
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH;
    req_if.queue_id = '0;
    req_if.value_in = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    idle_on         = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_req(REQ_PUSH, 3'd0, 32'h1234_5678);
    send_req(REQ_POP, 3'd3, 32'h0);
    write_enable('1);
    send_req(REQ_POP, 3'd0, 32'h0);
    send_req(REQ_CLEAR, 3'd1, 32'h0);
    send_req(REQ_QUERY, 3'd2, 32'h0);
    send_req(REQ_PUSH, 3'd0, 32'h0000_0000);
    send_req(REQ_PUSH, 3'd0, 32'hFFFF_FFFF);
    send_req(REQ_PUSH, 3'd0, 32'hA5A5_5A5A);
    send_req(REQ_QUERY, 3'd0, $urandom);
    send_req(REQ_POP, 3'd0, 32'h0);
    send_req(REQ_PUSH, 3'd7, 32'h8000_0001);
    send_req(REQ_PUSH, 3'd7, 32'h7FFF_FFFE);
    send_req(REQ_CLEAR, 3'd0, 32'h0);
    send_req(REQ_PUSH, 3'd3, 32'h5555_AAAA);
    send_req(REQ_POP, 3'd3, 32'h0);
    send_req(REQ_POP, 3'd3, 32'h0);
    write_enable(8'h7F);
    send_req(REQ_POP, 3'd7, 32'h0);
    send_req(REQ_PUSH, 3'd7, 32'hDEAD_BEEF);
    write_enable('1);
    send_req(REQ_QUERY, 3'd7, 32'h0);
    send_req(REQ_POP, 3'd7, 32'h0);
    send_req(REQ_CLEAR, 3'd7, 32'h0);

    write_enable(8'hC3);
    repeat (25) send_random(8'hC3);
    drain_results();
    repeat (25) send_random(8'hC3);
    run_random(8'h3C, 30);
    run_random(8'h00, 10);
    run_random(8'hFF, 25);

    write_enable('1);
    fill = sb.nodes_left() + 5;
    repeat (fill) begin
      send_req(REQ_PUSH, QID_W'($urandom_range(0, QUEUE_COUNT - 1)), $urandom);
    end
    repeat (30) send_random('1);

    run_random(QUEUE_COUNT'($urandom_range(1, 254)), 30);
    run_random(8'h01, 30);
    run_random(8'h80, 30);

    write_enable('1);
    idle_on = 1'b0;
    repeat (50) send_random('1);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_multi_queue_linked_fifo OK");
    end else begin
      $display("tb_multi_queue_linked_fifo NOT OK");
    end
    $finish;
  end

endmodule
